>>> sv/kts_pkg.sv
// shared types and constants for the keyframe track sampler
package kts_pkg;

    localparam int MAX_TRACKS_DEF = 16;
    localparam int MAX_FRAMES_DEF = 64;
    localparam int NCOMP = 9;
    localparam int DIV_STEPS = 48;

    typedef struct packed {
        logic               mode;
        logic [63:0]        target_key;
        logic signed [31:0] sample_time;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
        logic signed [31:0] scl_x;
        logic signed [31:0] scl_y;
        logic signed [31:0] scl_z;
    } req_t;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] out_time;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [31:0] out_rot_x;
        logic signed [31:0] out_rot_y;
        logic signed [31:0] out_rot_z;
        logic signed [31:0] out_scl_x;
        logic signed [31:0] out_scl_y;
        logic signed [31:0] out_scl_z;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0]          tm;
        logic [NCOMP-1:0][31:0]      comp;
    } frame_t;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

endpackage

>>> sv/keyframe_track_sampler_top.sv
// keyframe track sampler: track table, frame store, sequencer and lerp datapath
// sequence: track search compares the stored tracks one by one, then add scans the
//   frames for the insert point and shifts the later ones up; evaluate checks the
//   end frames, scans for the bracketing pair, then divides and does nine multiply-adds
// throughput: one beat at a time, next request taken once the result is registered
// reset: control state and track count clear; track and frame stores are not cleared
module keyframe_track_sampler_top
    import kts_pkg::*;
#(
    parameter int MAX_TRACKS = MAX_TRACKS_DEF,
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int TW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int TCW = $clog2(MAX_TRACKS + 1);
    localparam int NW  = $clog2(MAX_FRAMES + 1);
    localparam int FD  = MAX_TRACKS * MAX_FRAMES;
    localparam int FAW = $clog2(FD);
    localparam int TRW = 64 + NW;
    localparam int FRW = $bits(frame_t);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_TF    = 5'd1;
    localparam logic [4:0] S_TC    = 5'd2;
    localparam logic [4:0] S_ACHK  = 5'd3;
    localparam logic [4:0] S_PS    = 5'd4;
    localparam logic [4:0] S_PC    = 5'd5;
    localparam logic [4:0] S_SHR   = 5'd6;
    localparam logic [4:0] S_SHW   = 5'd7;
    localparam logic [4:0] S_INS   = 5'd8;
    localparam logic [4:0] S_ECHK  = 5'd9;
    localparam logic [4:0] S_EF0   = 5'd10;
    localparam logic [4:0] S_EF0C  = 5'd11;
    localparam logic [4:0] S_EFL   = 5'd12;
    localparam logic [4:0] S_EFLC  = 5'd13;
    localparam logic [4:0] S_EB    = 5'd14;
    localparam logic [4:0] S_EBC   = 5'd15;
    localparam logic [4:0] S_DIV   = 5'd16;
    localparam logic [4:0] S_LM    = 5'd17;
    localparam logic [4:0] S_LA    = 5'd18;
    localparam logic [4:0] S_FIN   = 5'd19;

    logic [4:0]     state_reg, state_next;
    req_t           item_reg, item_next;
    logic [TCW-1:0] tcount_reg, tcount_next;
    logic [TCW-1:0] idx_reg, idx_next;
    logic [TW-1:0]  tr_reg, tr_next;
    logic [NW-1:0]  n_reg, n_next;
    logic [NW-1:0]  sh_reg, sh_next;
    logic           newtrk_reg, newtrk_next;
    logic [FAW-1:0] base_reg, base_next;
    logic [NW-1:0]  pos_reg, pos_next;
    logic [3:0]     c_reg, c_next;
    frame_t         fa_reg, fa_next;
    frame_t         fb_reg, fb_next;
    frame_t         res_reg, res_next;
    logic           ok_reg, ok_next;
    logic [16:0]    f_reg, f_next;
    logic signed [50:0] prod_reg, prod_next;
    logic           rv_reg, rv_next;
    rsp_t           rsp_reg, rsp_next;

    logic           trk_we;
    logic [TW-1:0]  trk_waddr, trk_raddr;
    logic [TRW-1:0] trk_wdata, trk_rdata;
    logic           frm_we;
    logic [FAW-1:0] frm_waddr, frm_raddr;
    frame_t         frm_wdata, frm_q;
    logic [FRW-1:0] frm_rdata;
    logic           div_start, div_done;
    logic [16:0]    div_q;
    logic [47:0]    div_dvd;
    logic [31:0]    div_dsr;
    logic signed [32:0] num, den, dlt;
    logic signed [50:0] sum;
    frame_t         new_frame;
    logic [63:0]    q_key;
    logic [NW-1:0]  q_cnt;

    assign frm_q = frame_t'(frm_rdata);
    assign q_key = trk_rdata[TRW-1:NW];
    assign q_cnt = trk_rdata[NW-1:0];

    always_comb
    begin
        new_frame.tm      = item_reg.sample_time;
        new_frame.comp[0] = item_reg.pos_x;
        new_frame.comp[1] = item_reg.pos_y;
        new_frame.comp[2] = item_reg.pos_z;
        new_frame.comp[3] = item_reg.rot_x;
        new_frame.comp[4] = item_reg.rot_y;
        new_frame.comp[5] = item_reg.rot_z;
        new_frame.comp[6] = item_reg.scl_x;
        new_frame.comp[7] = item_reg.scl_y;
        new_frame.comp[8] = item_reg.scl_z;
    end

    always_comb
    begin
        num = {item_reg.sample_time[31], item_reg.sample_time}
            - {fa_reg.tm[31], fa_reg.tm};
        den = {fb_reg.tm[31], fb_reg.tm} - {fa_reg.tm[31], fa_reg.tm};
        div_dvd = {num[31:0], 16'd0};
        div_dsr = (den < 33'sd1) ? 32'd1 : den[31:0];
        dlt = {fb_reg.comp[c_reg][31], fb_reg.comp[c_reg]}
            - {fa_reg.comp[c_reg][31], fa_reg.comp[c_reg]};
        sum = {{19{fa_reg.comp[c_reg][31]}}, fa_reg.comp[c_reg]} + (prod_reg >>> 16);
    end

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        tcount_next = tcount_reg;
        idx_next    = idx_reg;
        tr_next     = tr_reg;
        n_next      = n_reg;
        sh_next     = sh_reg;
        newtrk_next = newtrk_reg;
        base_next   = base_reg;
        pos_next    = pos_reg;
        c_next      = c_reg;
        fa_next     = fa_reg;
        fb_next     = fb_reg;
        res_next    = res_reg;
        ok_next     = ok_reg;
        f_next      = f_reg;
        prod_next   = prod_reg;
        rv_next     = rv_reg;
        rsp_next    = rsp_reg;
        trk_we      = 1'b0;
        trk_waddr   = tr_reg;
        trk_wdata   = {item_reg.target_key, n_reg + NW'(1)};
        trk_raddr   = idx_reg[TW-1:0];
        frm_we      = 1'b0;
        frm_waddr   = base_reg + FAW'(pos_reg);
        frm_wdata   = new_frame;
        frm_raddr   = base_reg + FAW'(pos_reg);
        div_start   = 1'b0;

        if (rv_reg && !rsp_stall)
        begin
            rv_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    idx_next   = '0;
                    c_next     = '0;
                    res_next   = '0;
                    ok_next    = 1'b0;
                    state_next = S_TF;
                end
            end
            S_TF:
            begin
                if (idx_reg == tcount_reg)
                begin
                    if (item_reg.mode == MODE_EVAL || tcount_reg == TCW'(MAX_TRACKS))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        tr_next     = tcount_reg[TW-1:0];
                        n_next      = '0;
                        newtrk_next = 1'b1;
                        state_next  = S_ACHK;
                    end
                end
                else
                begin
                    state_next = S_TC;
                end
            end
            S_TC:
            begin
                if (q_key == item_reg.target_key)
                begin
                    tr_next     = idx_reg[TW-1:0];
                    n_next      = q_cnt;
                    newtrk_next = 1'b0;
                    state_next  = (item_reg.mode == MODE_EVAL) ? S_ECHK : S_ACHK;
                end
                else
                begin
                    idx_next   = idx_reg + TCW'(1);
                    state_next = S_TF;
                end
            end
            S_ACHK:
            begin
                base_next = FAW'(tr_reg * MAX_FRAMES);
                pos_next  = '0;
                sh_next   = n_reg;
                state_next = (n_reg >= NW'(MAX_FRAMES)) ? S_FIN : S_PS;
            end
            S_PS:
            begin
                state_next = (pos_reg == n_reg) ? S_SHR : S_PC;
                c_next     = '0;
                idx_next   = TCW'(0);
            end
            S_PC:
            begin
                if (frm_q.tm <= item_reg.sample_time)
                begin
                    pos_next   = pos_reg + NW'(1);
                    state_next = S_PS;
                end
                else
                begin
                    state_next = S_SHR;
                end
                frm_raddr = base_reg + FAW'(pos_reg + NW'(1));
            end
            S_SHR:
            begin
                frm_raddr = base_reg + FAW'(sh_reg) - FAW'(1);
                state_next = (sh_reg == pos_reg) ? S_INS : S_SHW;
            end
            S_SHW:
            begin
                frm_we    = 1'b1;
                frm_waddr = base_reg + FAW'(sh_reg);
                frm_wdata = frm_q;
                sh_next   = sh_reg - NW'(1);
                state_next = S_SHR;
            end
            S_INS:
            begin
                frm_we  = 1'b1;
                trk_we  = 1'b1;
                if (newtrk_reg)
                begin
                    tcount_next = tcount_reg + TCW'(1);
                end
                ok_next    = 1'b1;
                state_next = S_FIN;
            end
            S_ECHK:
            begin
                base_next  = FAW'(tr_reg * MAX_FRAMES);
                state_next = (n_reg == '0 || n_reg > NW'(MAX_FRAMES)) ? S_FIN : S_EF0;
            end
            S_EF0:
            begin
                frm_raddr  = base_reg;
                state_next = S_EF0C;
            end
            S_EF0C:
            begin
                fa_next = frm_q;
                if (n_reg == NW'(1) || item_reg.sample_time <= frm_q.tm)
                begin
                    res_next   = frm_q;
                    ok_next    = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_EFL;
                end
            end
            S_EFL:
            begin
                frm_raddr  = base_reg + FAW'(n_reg) - FAW'(1);
                pos_next   = NW'(1);
                state_next = S_EFLC;
            end
            S_EFLC:
            begin
                if (item_reg.sample_time >= frm_q.tm)
                begin
                    res_next   = frm_q;
                    ok_next    = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_EB;
                end
            end
            S_EB:
            begin
                frm_raddr  = base_reg + FAW'(pos_reg);
                state_next = S_EBC;
            end
            S_EBC:
            begin
                if (pos_reg < n_reg - NW'(1) && frm_q.tm < item_reg.sample_time)
                begin
                    fa_next    = frm_q;
                    pos_next   = pos_reg + NW'(1);
                    state_next = S_EB;
                end
                else
                begin
                    fb_next    = frm_q;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    f_next     = div_q;
                    c_next     = '0;
                    state_next = S_LM;
                end
                else if (c_reg == '0)
                begin
                    div_start = 1'b1;
                    c_next    = 4'd1;
                end
            end
            S_LM:
            begin
                prod_next  = 51'(dlt * $signed({1'b0, f_reg}));
                state_next = S_LA;
            end
            S_LA:
            begin
                res_next.comp[c_reg] = sum[31:0];
                if (c_reg == 4'(NCOMP - 1))
                begin
                    res_next.tm = item_reg.sample_time;
                    ok_next     = 1'b1;
                    state_next  = S_FIN;
                end
                else
                begin
                    c_next     = c_reg + 4'd1;
                    state_next = S_LM;
                end
            end
            S_FIN:
            begin
                if (!rv_reg || !rsp_stall)
                begin
                    rv_next            = 1'b1;
                    rsp_next.ok        = ok_reg;
                    rsp_next.out_time  = res_reg.tm;
                    rsp_next.out_pos_x = res_reg.comp[0];
                    rsp_next.out_pos_y = res_reg.comp[1];
                    rsp_next.out_pos_z = res_reg.comp[2];
                    rsp_next.out_rot_x = res_reg.comp[3];
                    rsp_next.out_rot_y = res_reg.comp[4];
                    rsp_next.out_rot_z = res_reg.comp[5];
                    rsp_next.out_scl_x = res_reg.comp[6];
                    rsp_next.out_scl_y = res_reg.comp[7];
                    rsp_next.out_scl_z = res_reg.comp[8];
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            tcount_reg <= '0;
            rv_reg     <= 1'b0;
            c_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            tcount_reg <= tcount_next;
            rv_reg     <= rv_next;
            c_reg      <= c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        idx_reg    <= idx_next;
        tr_reg     <= tr_next;
        n_reg      <= n_next;
        sh_reg     <= sh_next;
        newtrk_reg <= newtrk_next;
        base_reg   <= base_next;
        pos_reg    <= pos_next;
        fa_reg     <= fa_next;
        fb_reg     <= fb_next;
        res_reg    <= res_next;
        ok_reg     <= ok_next;
        f_reg      <= f_next;
        prod_reg   <= prod_next;
        rsp_reg    <= rsp_next;
    end

    kts_ram #(
        .WIDTH(TRW),
        .DEPTH(MAX_TRACKS)
    ) u_trk (
        .clk   (clk),
        .we    (trk_we),
        .waddr (trk_waddr),
        .wdata (trk_wdata),
        .raddr (trk_raddr),
        .rdata (trk_rdata)
    );

    kts_ram #(
        .WIDTH(FRW),
        .DEPTH(FD)
    ) u_frm (
        .clk   (clk),
        .we    (frm_we),
        .waddr (frm_waddr),
        .wdata (frm_wdata),
        .raddr (frm_raddr),
        .rdata (frm_rdata)
    );

    kts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_q)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rv_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_tcount_max: assert property (@(posedge clk) disable iff (!rst_n)
        tcount_reg <= TCW'(MAX_TRACKS))
        else $error("track count above table size");
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside divide wait");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.ok) |-> (rsp.out_time == 32'sd0 && rsp.out_pos_x == 32'sd0))
        else $error("failed beat carries data");
    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && rv_reg && rsp_stall) |=> state_reg == S_FIN)
        else $error("result dropped while output stalled");
`endif

endmodule

>>> sv/kts_ram.sv
// simple dual port ram with registered read
module kts_ram
    import kts_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> sv/kts_div.sv
// bit-serial restoring divider for the interpolation fraction
module kts_div
    import kts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [16:0] quotient
);

    localparam int CW = $clog2(DIV_STEPS + 1);

    logic [32:0]   rem_reg, rem_next;
    logic [47:0]   dvd_reg, dvd_next;
    logic [31:0]   dsr_reg, dsr_next;
    logic [16:0]   q_reg, q_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [32:0]   sh;
    logic          fits;

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        sh        = {rem_reg[31:0], dvd_reg[47]};
        fits      = (sh >= {1'b0, dsr_reg});
        if (start)
        begin
            rem_next = '0;
            dvd_next = dividend;
            dsr_next = divisor;
            q_next   = '0;
            cnt_next = CW'(DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = fits ? (sh - {1'b0, dsr_reg}) : sh;
            dvd_next = {dvd_reg[46:0], 1'b0};
            q_next   = {q_reg[15:0], fits};
            cnt_next = cnt_reg - CW'(1);
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
